[src/battery_module_cell_monitor_macros.svh]
`ifndef BATTERY_MODULE_CELL_MONITOR_MACROS_SVH
`define BATTERY_MODULE_CELL_MONITOR_MACROS_SVH

// same-cycle implication
`define BMCM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BMCM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bmcm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bmcm_pkg;

    localparam int MAX_CELLS_DEF = 16;
    localparam int MAX_TEMPS_DEF = 8;

    localparam logic [4:0]        NUM_CELLS_RST = 5'd16;
    localparam logic [3:0]        NUM_TEMPS_RST = 4'd8;
    localparam logic [15:0]       EMPTY_MV_RST  = 16'd3000;
    localparam logic [15:0]       FULL_MV_RST   = 16'd4200;
    localparam logic [15:0]       DEAD_MV_RST   = 16'd2500;
    localparam logic [15:0]       TTL_MS_RST    = 16'd1000;
    localparam logic signed [7:0] MAX_TEMP_RST  = 8'sd60;

    localparam logic [5:0]        ALL_GROUPS      = 6'h3F;
    localparam logic signed [7:0] TEMP_NONE       = -8'sd128;
    localparam logic signed [7:0] TEMP_FLOOR      = -8'sd126;
    localparam logic signed [7:0] TEMP_LOW_START  = 8'sd126;
    localparam logic signed [7:0] TEMP_HIGH_START = -8'sd126;
    localparam logic [19:0]       TOTAL_LIMIT     = 20'hFFFFF;
    localparam logic [15:0]       CELL_LOW_START  = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_SET_CELL  = 3'd0,
        OP_SET_TEMP  = 3'd1,
        OP_GROUP     = 3'd2,
        OP_HEARTBEAT = 3'd3,
        OP_TICK      = 3'd4,
        OP_RECHECK   = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        CFG_NUM_CELLS = 3'd0,
        CFG_NUM_TEMPS = 3'd1,
        CFG_EMPTY_MV  = 3'd2,
        CFG_FULL_MV   = 3'd3,
        CFG_DEAD_MV   = 3'd4,
        CFG_TTL_MS    = 3'd5,
        CFG_MAX_TEMP  = 3'd6
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_FIN  = 2'd2
    } t_state;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [3:0]        slot_index;
        logic [15:0]       cell_mv;
        logic signed [7:0] temperature;
        logic [10:0]       message_id;
    } t_item;

    typedef struct packed {
        logic [19:0]       total_mv;
        logic [15:0]       lowest_cell_mv;
        logic [15:0]       highest_cell_mv;
        logic signed [7:0] lowest_temp;
        logic signed [7:0] highest_temp;
        logic              empty_flag;
        logic              full_flag;
        logic              dead_flag;
        logic              over_temp_flag;
        logic              alive;
        logic              populated;
    } t_result;

    typedef struct packed {
        logic init;
        logic cell_en;
        logic temp_en;
    } t_scan_ctl;

    typedef struct packed {
        logic [15:0] empty_mv;
        logic [15:0] full_mv;
        logic [15:0] dead_mv;
    } t_thresh;

    typedef struct packed {
        logic [19:0]       total_mv;
        logic [15:0]       lo_mv;
        logic [15:0]       hi_mv;
        logic signed [7:0] lo_temp;
        logic signed [7:0] hi_temp;
        logic              any_empty;
        logic              any_full;
        logic              any_dead;
        logic              have_temp;
    } t_stats;

endpackage

`default_nettype wire

[src/battery_module_cell_monitor.sv]
// channel | ports                              | handshake
// item    | i_item                             | start high, busy low
// result  | o_result                           | o_strobe, one cycle, no stall
// config  | i_cfg_we, i_cfg_index, i_cfg_wdata | i_cfg_we high
//
// cells and sensors sit in two rotating rings of stages; one pass
// over both rings updates and scans them
// an accepted item runs through ST_SCAN and ST_FIN, and the strobe is registered from
// ST_FIN; busy is low again in the strobe cycle, so the next item can start then
// synchronous active-low reset restores registers, readings, clock and flags; no stalls
`timescale 1ns / 1ps
`default_nettype none
`include "battery_module_cell_monitor_macros.svh"

module battery_module_cell_monitor
    import bmcm_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF,
    parameter int MAX_TEMPS = MAX_TEMPS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_item       i_item,
    output logic             o_strobe,
    output t_result          o_result,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata
);

    localparam int STEPS = (MAX_CELLS > MAX_TEMPS) ? MAX_CELLS : MAX_TEMPS;
    localparam int KW    = $clog2(STEPS + 1);
    localparam int CMPW  = (KW > 5) ? KW : 5;

    logic [4:0]        r_num_cells;
    logic [3:0]        r_num_temps;
    logic [15:0]       r_empty_mv;
    logic [15:0]       r_full_mv;
    logic [15:0]       r_dead_mv;
    logic [15:0]       r_ttl_ms;
    logic signed [7:0] r_max_temp;

    t_state            r_state;
    t_state            n_state;
    logic [KW-1:0]     r_k;
    t_item             r_item;
    logic [5:0]        r_groups;
    logic              r_populated;
    logic              r_reported;
    logic [31:0]       r_last_beat;
    logic [31:0]       r_now;
    logic              r_strobe;
    t_result           r_result;

    logic              accept;
    logic              scanning;
    logic              last_step;
    logic              cell_live;
    logic              temp_live;
    logic              cell_fit;
    logic              temp_fit;
    logic              cell_hit;
    logic              temp_hit;
    logic [15:0]       cell_head;
    logic [15:0]       cell_tail;
    logic signed [7:0] temp_head;
    logic signed [7:0] temp_tail;
    logic [6:0]        grp_raw;
    logic [2:0]        grp_bit;
    logic [31:0]       beat_age;
    logic              alive;
    logic              n_populated;
    t_scan_ctl         scan_ctl;
    t_thresh           thr;
    t_stats            stats;

    logic [15:0] cell_q [MAX_CELLS];
    logic [7:0]  temp_q [MAX_TEMPS];

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cells <= NUM_CELLS_RST;
            r_num_temps <= NUM_TEMPS_RST;
            r_empty_mv  <= EMPTY_MV_RST;
            r_full_mv   <= FULL_MV_RST;
            r_dead_mv   <= DEAD_MV_RST;
            r_ttl_ms    <= TTL_MS_RST;
            r_max_temp  <= MAX_TEMP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_CELLS: r_num_cells <= i_cfg_wdata[4:0];
                CFG_NUM_TEMPS: r_num_temps <= i_cfg_wdata[3:0];
                CFG_EMPTY_MV:  r_empty_mv  <= i_cfg_wdata;
                CFG_FULL_MV:   r_full_mv   <= i_cfg_wdata;
                CFG_DEAD_MV:   r_dead_mv   <= i_cfg_wdata;
                CFG_TTL_MS:    r_ttl_ms    <= i_cfg_wdata;
                CFG_MAX_TEMP:  r_max_temp  <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (start) n_state = ST_SCAN;
            ST_SCAN: if (last_step) n_state = ST_FIN;
            ST_FIN:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy     = 1'b1;
        scanning = 1'b0;
        case (r_state)
            ST_IDLE: busy = 1'b0;
            ST_SCAN: scanning = 1'b1;
            ST_FIN:  busy = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_k <= '0;
            end else if (scanning) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    // ring position and write selection
    assign last_step = (r_k == KW'(STEPS - 1));
    assign cell_live = scanning && (CMPW'(r_k) < CMPW'(MAX_CELLS));
    assign temp_live = scanning && (CMPW'(r_k) < CMPW'(MAX_TEMPS));
    assign cell_fit  = CMPW'(r_k) < CMPW'(r_num_cells);
    assign temp_fit  = CMPW'(r_k) < CMPW'(r_num_temps);
    assign cell_hit  = (r_item.opcode == OP_SET_CELL) && cell_fit
                       && (CMPW'(r_k) == CMPW'(r_item.slot_index));
    assign temp_hit  = (r_item.opcode == OP_SET_TEMP) && temp_fit
                       && (CMPW'(r_k) == CMPW'(r_item.slot_index));

    assign cell_head = cell_q[0];
    assign temp_head = temp_q[0];
    assign cell_tail = cell_hit ? r_item.cell_mv : cell_head;
    assign temp_tail = temp_hit ? r_item.temperature : temp_head;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_CELLS; gi++) begin : g_cell
            bmcm_stage #(
                .W       (16),
                .RST_VAL (16'd0)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (cell_live),
                .i_d     ((gi == MAX_CELLS - 1) ? cell_tail : cell_q[(gi + 1) % MAX_CELLS]),
                .o_q     (cell_q[gi])
            );
        end
        for (gi = 0; gi < MAX_TEMPS; gi++) begin : g_temp
            bmcm_stage #(
                .W       (8),
                .RST_VAL (TEMP_NONE)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (temp_live),
                .i_d     ((gi == MAX_TEMPS - 1) ? temp_tail : temp_q[(gi + 1) % MAX_TEMPS]),
                .o_q     (temp_q[gi])
            );
        end
    endgenerate

    always_comb begin
        scan_ctl.init    = accept;
        scan_ctl.cell_en = cell_live && cell_fit;
        scan_ctl.temp_en = temp_live && temp_fit;
        thr.empty_mv     = r_empty_mv;
        thr.full_mv      = r_full_mv;
        thr.dead_mv      = r_dead_mv;
    end

    bmcm_scan u_scan (
        .i_clk     (i_clk),
        .i_ctl     (scan_ctl),
        .i_thr     (thr),
        .i_cell_mv (cell_tail),
        .i_temp    (temp_tail),
        .o_stats   (stats)
    );

    // group, heartbeat and clock updates at acceptance
    assign grp_raw = i_item.message_id[10:4];
    assign grp_bit = 3'(grp_raw - 7'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups    <= '0;
            r_reported  <= 1'b0;
            r_last_beat <= '0;
            r_now       <= '0;
        end else if (accept) begin
            case (i_item.opcode)
                OP_GROUP: begin
                    if (grp_raw inside {[7'd2:7'd7]}) r_groups[grp_bit] <= 1'b1;
                end
                OP_HEARTBEAT: begin
                    r_last_beat <= r_now;
                    r_reported  <= 1'b1;
                end
                OP_TICK: r_now <= r_now + 32'd1;
                default: ;
            endcase
        end
    end

    assign beat_age    = r_now - r_last_beat;
    assign alive       = r_reported ? (beat_age < {16'd0, r_ttl_ms})
                                    : (r_now < {16'd0, r_ttl_ms});
    assign n_populated = (r_item.opcode == OP_RECHECK)
                         ? ((r_groups == ALL_GROUPS) && stats.have_temp)
                         : r_populated;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_populated <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= (r_state == ST_FIN);
            if (r_state == ST_FIN) r_populated <= n_populated;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN) begin
            r_result.total_mv        <= stats.total_mv;
            r_result.lowest_cell_mv  <= stats.lo_mv;
            r_result.highest_cell_mv <= stats.hi_mv;
            r_result.lowest_temp     <= stats.lo_temp;
            r_result.highest_temp    <= stats.hi_temp;
            r_result.empty_flag      <= n_populated && stats.any_empty;
            r_result.full_flag       <= n_populated && stats.any_full;
            r_result.dead_flag       <= n_populated && stats.any_dead;
            r_result.over_temp_flag  <= stats.hi_temp > r_max_temp;
            r_result.alive           <= alive;
            r_result.populated       <= n_populated;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `BMCM_ASSERT_NEXT(a_accept_scan, i_clk, i_rst_n, accept,
        (r_state == ST_SCAN) && (r_k == '0), "accepted item did not start a pass")
    `BMCM_ASSERT_NEXT(a_fin_strobe, i_clk, i_rst_n, r_state == ST_FIN,
        o_strobe && !busy, "finished pass gave no result")
    `BMCM_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_strobe,
        !o_strobe, "result shown twice")
    `BMCM_ASSERT_NOW(a_step_range, i_clk, i_rst_n, r_state == ST_SCAN,
        CMPW'(r_k) < CMPW'(STEPS), "ring step out of range")

endmodule

`default_nettype wire

[src/bmcm_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module bmcm_stage
    import bmcm_pkg::*;
#(
    parameter int           W       = 16,
    parameter logic [W-1:0] RST_VAL = '0
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_shift,
    input  wire logic [W-1:0] i_d,
    output logic      [W-1:0] o_q
);

    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= RST_VAL;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

[src/bmcm_scan.sv]
`timescale 1ns / 1ps
`default_nettype none

module bmcm_scan
    import bmcm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_scan_ctl         i_ctl,
    input  wire t_thresh           i_thr,
    input  wire logic [15:0]       i_cell_mv,
    input  wire logic signed [7:0] i_temp,
    output t_stats                 o_stats
);

    logic [19:0]       r_total;
    logic [15:0]       r_lo;
    logic [15:0]       r_hi;
    logic signed [7:0] r_tlo;
    logic signed [7:0] r_thi;
    logic              r_empty;
    logic              r_full;
    logic              r_dead;
    logic              r_have;
    logic [20:0]       n_sum;

    assign n_sum = {1'b0, r_total} + 21'(i_cell_mv);

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_total <= '0;
            r_lo    <= CELL_LOW_START;
            r_hi    <= '0;
            r_tlo   <= TEMP_LOW_START;
            r_thi   <= TEMP_HIGH_START;
            r_empty <= 1'b0;
            r_full  <= 1'b0;
            r_dead  <= 1'b0;
            r_have  <= 1'b0;
        end else begin
            if (i_ctl.cell_en) begin
                r_total <= n_sum[20] ? TOTAL_LIMIT : n_sum[19:0];
                if (i_cell_mv < r_lo) r_lo <= i_cell_mv;
                if (i_cell_mv > r_hi) r_hi <= i_cell_mv;
                if (i_cell_mv <= i_thr.empty_mv) r_empty <= 1'b1;
                if (i_cell_mv >= i_thr.full_mv) r_full <= 1'b1;
                if (i_cell_mv <= i_thr.dead_mv) r_dead <= 1'b1;
            end
            if (i_ctl.temp_en) begin
                if (i_temp > TEMP_NONE) r_have <= 1'b1;
                if (i_temp >= TEMP_FLOOR) begin
                    if (i_temp < r_tlo) r_tlo <= i_temp;
                    if (i_temp > r_thi) r_thi <= i_temp;
                end
            end
        end
    end

    always_comb begin
        o_stats.total_mv  = r_total;
        o_stats.lo_mv     = r_lo;
        o_stats.hi_mv     = r_hi;
        o_stats.lo_temp   = r_tlo;
        o_stats.hi_temp   = r_thi;
        o_stats.any_empty = r_empty;
        o_stats.any_full  = r_full;
        o_stats.any_dead  = r_dead;
        o_stats.have_temp = r_have;
    end

endmodule

`default_nettype wire

[tb/battery_module_cell_monitor_tb.sv]
`timescale 1ns / 1ps

module battery_module_cell_monitor_tb;
    import bmcm_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 24;
    localparam int          PHASES       = 8;
    localparam int          PHASE_ITEMS  = 250;
    localparam logic [2:0]  OP_SPARE_A   = 3'd6;
    localparam logic [2:0]  OP_SPARE_B   = 3'd7;

    class cell_monitor_predictor;
        logic [15:0]       cell_reading [MAX_CELLS_DEF];
        logic signed [7:0] sensor_reading [MAX_TEMPS_DEF];
        logic [5:0]        group_mask;
        bit                module_populated;
        bit                beat_received;
        logic [31:0]       beat_stamp;
        logic [31:0]       clock_ms;

        logic [4:0]        n_cells;
        logic [3:0]        n_sensors;
        logic [15:0]       empty_level;
        logic [15:0]       full_level;
        logic [15:0]       dead_level;
        logic [15:0]       heartbeat_ttl;
        logic signed [7:0] temp_limit;

        t_result summaries_due [$];
        int      mismatches;

        function new();
            foreach (cell_reading[i]) cell_reading[i] = '0;
            foreach (sensor_reading[i]) sensor_reading[i] = TEMP_NONE;
            group_mask       = '0;
            module_populated = 1'b0;
            beat_received    = 1'b0;
            beat_stamp       = '0;
            clock_ms         = '0;
            n_cells          = NUM_CELLS_RST;
            n_sensors        = NUM_TEMPS_RST;
            empty_level      = EMPTY_MV_RST;
            full_level       = FULL_MV_RST;
            dead_level       = DEAD_MV_RST;
            heartbeat_ttl    = TTL_MS_RST;
            temp_limit       = MAX_TEMP_RST;
            mismatches       = 0;
        endfunction

        function int fitted_cells();
            return (n_cells > MAX_CELLS_DEF) ? MAX_CELLS_DEF : int'(n_cells);
        endfunction

        function int fitted_sensors();
            return (n_sensors > MAX_TEMPS_DEF) ? MAX_TEMPS_DEF : int'(n_sensors);
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] d);
            case (idx)
                CFG_NUM_CELLS: n_cells = d[4:0];
                CFG_NUM_TEMPS: n_sensors = d[3:0];
                CFG_EMPTY_MV:  empty_level = d;
                CFG_FULL_MV:   full_level = d;
                CFG_DEAD_MV:   dead_level = d;
                CFG_TTL_MS:    heartbeat_ttl = d;
                CFG_MAX_TEMP:  temp_limit = d[7:0];
                default: ;
            endcase
        endfunction

        function void accept_item(t_item it);
            int                nc;
            int                nt;
            int                grp;
            logic [20:0]       sum;
            logic [15:0]       lo;
            logic [15:0]       hi;
            logic signed [7:0] tlo;
            logic signed [7:0] thi;
            bit                any_empty;
            bit                any_full;
            bit                any_dead;
            bit                have_temp;
            t_result           r;
            nc        = fitted_cells();
            nt        = fitted_sensors();
            sum       = '0;
            lo        = CELL_LOW_START;
            hi        = '0;
            tlo       = TEMP_LOW_START;
            thi       = TEMP_HIGH_START;
            any_empty = 1'b0;
            any_full  = 1'b0;
            any_dead  = 1'b0;
            have_temp = 1'b0;
            case (it.opcode)
                OP_SET_CELL: if (it.slot_index < nc) cell_reading[it.slot_index] = it.cell_mv;
                OP_SET_TEMP: if (it.slot_index < nt) sensor_reading[it.slot_index] = it.temperature;
                OP_GROUP: begin
                    grp = it.message_id[10:4];
                    if (grp >= 2 && grp <= 7) group_mask[grp - 2] = 1'b1;
                end
                OP_HEARTBEAT: begin
                    beat_stamp    = clock_ms;
                    beat_received = 1'b1;
                end
                OP_TICK: clock_ms = clock_ms + 32'd1;
                OP_RECHECK: begin
                    for (int i = 0; i < nt; i++)
                        if (sensor_reading[i] > TEMP_NONE) have_temp = 1'b1;
                    module_populated = (group_mask == ALL_GROUPS) && have_temp;
                end
                default: ;
            endcase
            for (int i = 0; i < nc; i++) begin
                sum = sum + cell_reading[i];
                if (cell_reading[i] < lo) lo = cell_reading[i];
                if (cell_reading[i] > hi) hi = cell_reading[i];
                if (cell_reading[i] <= empty_level) any_empty = 1'b1;
                if (cell_reading[i] >= full_level) any_full = 1'b1;
                if (cell_reading[i] <= dead_level) any_dead = 1'b1;
            end
            if (sum > TOTAL_LIMIT) sum = TOTAL_LIMIT;
            for (int i = 0; i < nt; i++) begin
                if (sensor_reading[i] >= TEMP_FLOOR) begin
                    if (sensor_reading[i] < tlo) tlo = sensor_reading[i];
                    if (sensor_reading[i] > thi) thi = sensor_reading[i];
                end
            end
            r.total_mv        = sum[19:0];
            r.lowest_cell_mv  = lo;
            r.highest_cell_mv = hi;
            r.lowest_temp     = tlo;
            r.highest_temp    = thi;
            r.empty_flag      = module_populated && any_empty;
            r.full_flag       = module_populated && any_full;
            r.dead_flag       = module_populated && any_dead;
            r.over_temp_flag  = thi > temp_limit;
            if (beat_received)
                r.alive = (clock_ms - beat_stamp) < {16'd0, heartbeat_ttl};
            else
                r.alive = clock_ms < {16'd0, heartbeat_ttl};
            r.populated       = module_populated;
            summaries_due.push_back(r);
        endfunction

        function string describe(t_result r);
            return $sformatf("sum=%0d lo=%0d hi=%0d tlo=%0d thi=%0d e/f/d=%b%b%b ot=%b al=%b pop=%b",
                r.total_mv, r.lowest_cell_mv, r.highest_cell_mv, $signed(r.lowest_temp),
                $signed(r.highest_temp), r.empty_flag, r.full_flag, r.dead_flag,
                r.over_temp_flag, r.alive, r.populated);
        endfunction

        function void compare_summary(t_result got);
            t_result want;
            if (summaries_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %s", describe(got));
            end else begin
                want = summaries_due.pop_front();
                if (got.total_mv !== want.total_mv
                        || got.lowest_cell_mv !== want.lowest_cell_mv
                        || got.highest_cell_mv !== want.highest_cell_mv
                        || got.lowest_temp !== want.lowest_temp
                        || got.highest_temp !== want.highest_temp
                        || got.empty_flag !== want.empty_flag
                        || got.full_flag !== want.full_flag
                        || got.dead_flag !== want.dead_flag
                        || got.over_temp_flag !== want.over_temp_flag
                        || got.alive !== want.alive
                        || got.populated !== want.populated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t\n  exp %s\n  got %s", $realtime,
                                 describe(want), describe(got));
                end
            end
        endfunction

        function int pending();
            return summaries_due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_strobe;
    t_result     o_result;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_wdata;

    cell_monitor_predictor monitor_model = new();
    logic [15:0]           reg_plan [7];
    int                    burst_left = 0;
    int                    cycle_count = 0;

    battery_module_cell_monitor i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) monitor_model.compare_summary(o_result);
            if (i_cfg_we) monitor_model.write_reg(i_cfg_index, i_cfg_wdata);
            if (start && !busy) monitor_model.accept_item(i_item);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(input t_item it);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // bursts of items with random gaps between them
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25));
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (monitor_model.pending() != 0 || busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs();
        t_cfg_reg r;
        r = r.first();
        do begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= r;
            i_cfg_wdata <= reg_plan[r];
            @(posedge i_clk);
            r = r.next();
        end while (r != r.first());
        i_cfg_we <= 1'b0;
    endtask

    task automatic choose_setting(input int phase);
        logic [4:0]        cells;
        logic [3:0]        sensors;
        logic [15:0]       empty_lvl;
        logic [15:0]       full_lvl;
        logic [15:0]       dead_lvl;
        logic [15:0]       ttl;
        logic signed [7:0] limit;
        case (phase)
            0: begin
                cells = NUM_CELLS_RST; sensors = NUM_TEMPS_RST; empty_lvl = EMPTY_MV_RST;
                full_lvl = FULL_MV_RST; dead_lvl = DEAD_MV_RST; ttl = 16'd6;
                limit = MAX_TEMP_RST;
            end
            1: begin
                cells = 5'd0; sensors = 4'd0; empty_lvl = 16'd0; full_lvl = 16'd0;
                dead_lvl = 16'd0; ttl = 16'd1; limit = -8'sd128;
            end
            2: begin
                cells = 5'd31; sensors = 4'd15; empty_lvl = 16'hFFFF; full_lvl = 16'hFFFF;
                dead_lvl = 16'hFFFF; ttl = 16'hFFFF; limit = 8'sd127;
            end
            3: begin
                cells = 5'($urandom_range(1, 16)); sensors = 4'($urandom_range(1, 8));
                empty_lvl = EMPTY_MV_RST; full_lvl = FULL_MV_RST; dead_lvl = DEAD_MV_RST;
                ttl = 16'd0; limit = 8'($urandom_range(0, 80));
            end
            default: begin
                cells     = 5'($urandom_range(0, 31));
                sensors   = 4'($urandom_range(0, 15));
                empty_lvl = 16'($urandom_range(2000, 3800));
                full_lvl  = 16'($urandom_range(3500, 4400));
                dead_lvl  = 16'($urandom_range(1500, empty_lvl));
                ttl       = 16'($urandom_range(1, 12));
                limit     = 8'($urandom);
            end
        endcase
        // unused high bits of the narrow registers carry noise
        reg_plan[CFG_NUM_CELLS] = {11'($urandom), cells};
        reg_plan[CFG_NUM_TEMPS] = {12'($urandom), sensors};
        reg_plan[CFG_EMPTY_MV]  = empty_lvl;
        reg_plan[CFG_FULL_MV]   = full_lvl;
        reg_plan[CFG_DEAD_MV]   = dead_lvl;
        reg_plan[CFG_TTL_MS]    = ttl;
        reg_plan[CFG_MAX_TEMP]  = {8'($urandom), limit};
    endtask

    function automatic t_item mk(logic [2:0] op, logic [3:0] slot, logic [15:0] mv,
                                 logic signed [7:0] temp, logic [10:0] id);
        t_item it;
        it.opcode      = op;
        it.slot_index  = slot;
        it.cell_mv     = mv;
        it.temperature = temp;
        it.message_id  = id;
        return it;
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    pick;
        int    nc;
        int    nt;
        it  = t_item'({$urandom, $urandom});
        nc  = monitor_model.fitted_cells();
        nt  = monitor_model.fitted_sensors();
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            it.opcode = OP_SET_CELL;
            if (nc > 0 && $urandom_range(0, 4) != 0) it.slot_index = 4'($urandom_range(0, nc - 1));
            case ($urandom_range(0, 5))
                0: it.cell_mv = 16'($urandom);
                1: it.cell_mv = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                2: it.cell_mv = monitor_model.empty_level + 16'($urandom_range(0, 2)) - 16'd1;
                3: it.cell_mv = monitor_model.full_level + 16'($urandom_range(0, 2)) - 16'd1;
                4: it.cell_mv = monitor_model.dead_level + 16'($urandom_range(0, 2)) - 16'd1;
                default: it.cell_mv = 16'($urandom_range(1500, 4500));
            endcase
        end else if (pick < 50) begin
            it.opcode = OP_SET_TEMP;
            if (nt > 0 && $urandom_range(0, 4) != 0) it.slot_index = 4'($urandom_range(0, nt - 1));
            case ($urandom_range(0, 4))
                0: it.temperature = 8'($urandom);
                1: it.temperature = 8'(-$urandom_range(126, 128));
                2: it.temperature = monitor_model.temp_limit + 8'($urandom_range(0, 2)) - 8'sd1;
                3: it.temperature = $urandom_range(0, 1) ? 8'sd127 : -8'sd125;
                default: it.temperature = 8'($urandom_range(10, 70));
            endcase
        end else if (pick < 65) begin
            it.opcode = OP_GROUP;
            if ($urandom_range(0, 3) != 0)
                it.message_id = {7'($urandom_range(2, 7)), 4'($urandom)};
        end else if (pick < 73) begin
            it.opcode = OP_HEARTBEAT;
        end else if (pick < 90) begin
            it.opcode = OP_TICK;
        end else if (pick < 98) begin
            it.opcode = OP_RECHECK;
        end else begin
            it.opcode = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        end
        return it;
    endfunction

    initial begin
        t_item directed [$];
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_item      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_NUM_CELLS;
        i_cfg_wdata <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: extremes, sentinels, ignored slots and groups
        directed = '{
            mk(OP_TICK, 4'd0, 16'd0, 8'sd0, 11'd0),
            mk(OP_SET_CELL, 4'd0, 16'hFFFF, 8'sd0, 11'd0),
            mk(OP_SET_CELL, 4'd15, 16'h0000, 8'sd0, 11'd0),
            mk(OP_SET_CELL, 4'd5, EMPTY_MV_RST, 8'sd0, 11'd0),
            mk(OP_SET_TEMP, 4'd0, 16'd0, 8'sd127, 11'd0),
            mk(OP_SET_TEMP, 4'd7, 16'd0, -8'sd127, 11'd0),
            mk(OP_SET_TEMP, 4'd1, 16'd0, -8'sd126, 11'd0),
            mk(OP_SET_TEMP, 4'd8, 16'd0, 8'sd5, 11'd0),
            mk(OP_SET_TEMP, 4'd15, 16'd0, 8'sd5, 11'd0),
            mk(OP_GROUP, 4'd0, 16'd0, 8'sd0, 11'h01F),
            mk(OP_GROUP, 4'd0, 16'd0, 8'sd0, 11'h080),
            mk(OP_GROUP, 4'd0, 16'd0, 8'sd0, 11'h7FF),
            mk(OP_RECHECK, 4'd0, 16'd0, 8'sd0, 11'd0),
            mk(OP_GROUP, 4'd0, 16'd0, 8'sd0, 11'h020),
            mk(OP_GROUP, 4'd0, 16'd0, 8'sd0, 11'h03F),
            mk(OP_GROUP, 4'd0, 16'd0, 8'sd0, 11'h040),
            mk(OP_GROUP, 4'd0, 16'd0, 8'sd0, 11'h05A),
            mk(OP_GROUP, 4'd0, 16'd0, 8'sd0, 11'h060),
            mk(OP_SPARE_A, 4'hF, 16'hFFFF, -8'sd1, 11'h7FF),
            mk(OP_GROUP, 4'd0, 16'd0, 8'sd0, 11'h07F),
            mk(OP_RECHECK, 4'd0, 16'd0, 8'sd0, 11'd0),
            mk(OP_SPARE_B, 4'hF, 16'hFFFF, -8'sd1, 11'h7FF),
            mk(OP_SET_TEMP, 4'd0, 16'd0, -8'sd128, 11'd0)
        };
        foreach (directed[i]) begin
            send_item(directed[i]);
            pace();
        end
        wait_drain();

        // short ttl: alive before and after the first heartbeat
        choose_setting(0);
        reg_plan[CFG_TTL_MS] = 16'd2;
        program_regs();
        directed = '{
            mk(OP_TICK, 4'd0, 16'd0, 8'sd0, 11'd0),
            mk(OP_TICK, 4'd0, 16'd0, 8'sd0, 11'd0),
            mk(OP_HEARTBEAT, 4'd0, 16'd0, 8'sd0, 11'd0),
            mk(OP_TICK, 4'd0, 16'd0, 8'sd0, 11'd0),
            mk(OP_TICK, 4'd0, 16'd0, 8'sd0, 11'd0),
            mk(OP_RECHECK, 4'd0, 16'd0, 8'sd0, 11'd0)
        };
        foreach (directed[i]) begin
            send_item(directed[i]);
            pace();
        end
        wait_drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            choose_setting(ph);
            program_regs();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(random_item());
                pace();
            end
            wait_drain();
        end

        if (monitor_model.mismatches == 0 && monitor_model.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/bmcm_pkg.sv
src/bmcm_stage.sv
src/bmcm_scan.sv
src/battery_module_cell_monitor.sv
tb/battery_module_cell_monitor_tb.sv
